FILE: sv/sacts_pkg.sv
// ----------------------------------------------------------------------------
// sacts_pkg
// Shared constants and helpers for the set-associative cache tag store.
// ----------------------------------------------------------------------------
package sacts_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_POLICY     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETS_LOG2  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_LOG2  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LOG2 = 2'd3;

  // register field widths
  localparam int SETS_LOG2_W  = 4;
  localparam int WAYS_LOG2_W  = 2;
  localparam int BLOCK_LOG2_W = 5;

  // replacement policy codes
  localparam logic POL_LRU  = 1'b0;
  localparam logic POL_FIFO = 1'b1;

  // access kinds
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // statistics counters
  localparam int                CNT_W   = 32;
  localparam logic [CNT_W-1:0]  CNT_MAX = '1;

  // largest s with 2**s <= n (elaboration only)
  function automatic int floor_log2(input int n);
    int s;
    s = 0;
    while ((s < 31) && ((64'd1 << (s + 1)) <= 64'(n)))
      s++;
    return s;
  endfunction

endpackage

FILE: sv/sacts_if.sv
// ----------------------------------------------------------------------------
// sacts_in_if / sacts_out_if
// Valid/ready channels for access beats in and result beats out.
// ----------------------------------------------------------------------------
interface sacts_in_if #(
  parameter int ADDR_W = 48
);
  logic              valid;
  logic              ready;
  logic              op;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output op, output address, input ready);
  modport sink   (input valid, input op, input address, output ready);
endinterface

interface sacts_out_if;
  import sacts_pkg::*;

  logic             valid;
  logic             ready;
  logic             hit;
  logic             mem_read;
  logic             mem_write;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] read_total;
  logic [CNT_W-1:0] write_total;

  modport source (output valid, output hit, output mem_read, output mem_write,
                  output hit_total, output miss_total, output read_total,
                  output write_total, input ready);
  modport sink   (input valid, input hit, input mem_read, input mem_write,
                  input hit_total, input miss_total, input read_total,
                  input write_total, output ready);
endinterface

FILE: sv/sacts_ram.sv
// ----------------------------------------------------------------------------
// sacts_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module sacts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: sv/set_assoc_cache_tag_store.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_store
// Tag store of a write-through, write-allocate set-associative cache.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : one access beat (op, address). op = write also flags a memory
//              write, since the cache is write-through.
//   out_chan : one result beat per access: hit, mem_read (any miss),
//              mem_write, and the four saturating statistics counters.
//   cfg_*    : register writes (policy, sets_log2, ways_log2, block_log2),
//              taken on any cycle with cfg_we high; write only while idle.
// Timing: the idle state accepts the beat and reads the set's row (all ways
//   plus fill count) from the tag RAM; the compare state then compares the
//   ways, reorders the row and writes it back, loading the result register
//   once that register is free. The row read/write-back of the tag RAM sets
//   the rate: no new access is taken until the last one is written back.
// Reset: synchronous. Registers return to their defaults, counters clear,
//   and a per-set flop marks every row empty, so no clearing pass is needed.
// Stall: a result waits in the output register; the next access is taken
//   meanwhile and holds in its compare cycle until the register frees up.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_store #(
  parameter int MAX_SETS     = 256,
  parameter int MAX_WAYS     = 8,
  parameter int ADDRESS_BITS = 48
) (
  input  logic                                clk,
  input  logic                                rst_n,
  sacts_in_if.sink                            in_chan,
  sacts_out_if.source                         out_chan,
  input  logic                                cfg_we,
  input  logic [sacts_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sacts_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import sacts_pkg::*;

  // geometry
  localparam int SET_W  = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
  localparam int CNT_FW = $clog2(MAX_WAYS + 1);         // fill count width
  localparam int TAG_W  = ADDRESS_BITS;
  localparam int ROW_W  = MAX_WAYS * TAG_W + CNT_FW;
  localparam int S_CAP  = floor_log2(MAX_SETS);
  localparam int W_CAP  = floor_log2(MAX_WAYS);

  localparam logic [SET_W-1:0] SET_ONES = '1;

  // sequencer
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  logic state_r, state_nxt;

  // configuration
  logic                    policy_r;
  logic [SETS_LOG2_W-1:0]  sets_log2_r;
  logic [WAYS_LOG2_W-1:0]  ways_log2_r;
  logic [BLOCK_LOG2_W-1:0] block_log2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r     <= POL_LRU;
      sets_log2_r  <= SETS_LOG2_W'(8);
      ways_log2_r  <= '0;
      block_log2_r <= BLOCK_LOG2_W'(6);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLICY:     policy_r     <= cfg_wdata[0];
        CFG_SETS_LOG2:  sets_log2_r  <= cfg_wdata[SETS_LOG2_W-1:0];
        CFG_WAYS_LOG2:  ways_log2_r  <= cfg_wdata[WAYS_LOG2_W-1:0];
        CFG_BLOCK_LOG2: block_log2_r <= cfg_wdata[BLOCK_LOG2_W-1:0];
        default: ;
      endcase
    end
  end

  // effective sizes, capped to what is built
  logic [4:0]        s_log;
  logic [2:0]        w_log;
  logic [CNT_FW-1:0] ways;

  assign s_log = ({1'b0, sets_log2_r} > 5'(S_CAP)) ? 5'(S_CAP) : {1'b0, sets_log2_r};
  assign w_log = ({1'b0, ways_log2_r} > 3'(W_CAP)) ? 3'(W_CAP) : {1'b0, ways_log2_r};
  assign ways  = CNT_FW'(1) << w_log;

  // address split at acceptance
  logic              in_acc;
  logic [SET_W-1:0]  set_idx, set_mask;
  logic [5:0]        tag_shamt;
  logic [TAG_W-1:0]  tag_in;
  logic [SET_W-1:0]  set_r;
  logic [TAG_W-1:0]  tag_r;
  logic              op_r;

  assign in_chan.ready = (state_r == ST_IDLE);
  assign in_acc        = in_chan.valid && in_chan.ready;

  assign set_mask  = ~(SET_ONES << s_log);
  assign set_idx   = SET_W'(in_chan.address >> block_log2_r) & set_mask;
  assign tag_shamt = 6'(block_log2_r) + 6'(s_log);
  assign tag_in    = in_chan.address >> tag_shamt;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r <= set_idx;
      tag_r <= tag_in;
      op_r  <= in_chan.op;
    end
  end

  // row store: all ways of a set plus its fill count
  logic             row_we;
  logic [ROW_W-1:0] row_rd, row_wr;
  logic [MAX_SETS-1:0] row_vld_r;   // row ever written since reset

  sacts_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (set_r),
    .wr_data (row_wr),
    .rd_en   (in_acc),
    .rd_addr (set_idx),
    .rd_data (row_rd)
  );

  // compare and reorder
  logic [TAG_W-1:0]  old_tag [MAX_WAYS+1];
  logic [TAG_W-1:0]  new_tag [MAX_WAYS];
  logic [CNT_FW-1:0] cnt_old, cnt_new, used, pos, lo, last;
  logic              hit, shift, append;

  always_comb begin
    for (int j = 0; j < MAX_WAYS; j++) begin
      old_tag[j] = row_rd[j*TAG_W +: TAG_W];
    end
    old_tag[MAX_WAYS] = '0;

    cnt_old = row_vld_r[set_r] ? row_rd[MAX_WAYS*TAG_W +: CNT_FW] : '0;
    used    = (cnt_old < ways) ? cnt_old : ways;

    // oldest matching way wins
    hit = 1'b0;
    pos = '0;
    for (int j = 0; j < MAX_WAYS; j++) begin
      if (!hit && (CNT_FW'(j) < used) && (old_tag[j] == tag_r)) begin
        hit = 1'b1;
        pos = CNT_FW'(j);
      end
    end

    shift  = (hit && (policy_r == POL_LRU)) || (!hit && (used == ways));
    append = !hit && (used < ways);
    lo     = hit ? pos : '0;
    last   = used - CNT_FW'(1);

    for (int j = 0; j < MAX_WAYS; j++) begin
      new_tag[j] = old_tag[j];
      if (shift) begin
        if (CNT_FW'(j) == last) begin
          new_tag[j] = tag_r;
        end else if ((CNT_FW'(j) >= lo) && (CNT_FW'(j) < last)) begin
          new_tag[j] = old_tag[j+1];
        end
      end else if (append && (CNT_FW'(j) == used)) begin
        new_tag[j] = tag_r;
      end
    end

    cnt_new = append ? (used + CNT_FW'(1)) : cnt_old;

    for (int j = 0; j < MAX_WAYS; j++) begin
      row_wr[j*TAG_W +: TAG_W] = new_tag[j];
    end
    row_wr[MAX_WAYS*TAG_W +: CNT_FW] = cnt_new;
  end

  // finish when the result register is free
  logic out_free;

  assign out_free = !out_chan.valid || out_chan.ready;
  assign row_we   = (state_r == ST_LOOK) && out_free;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_LOOK;
      ST_LOOK: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      row_vld_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (row_we) begin
        row_vld_r[set_r] <= 1'b1;
      end
    end
  end

  // statistics
  logic [CNT_W-1:0] hit_cnt_r, miss_cnt_r, rd_cnt_r, wr_cnt_r;
  logic [CNT_W-1:0] hit_cnt_nxt, miss_cnt_nxt, rd_cnt_nxt, wr_cnt_nxt;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + CNT_W'(1);
  endfunction

  always_comb begin
    hit_cnt_nxt  = hit  ? sat_inc(hit_cnt_r)  : hit_cnt_r;
    miss_cnt_nxt = !hit ? sat_inc(miss_cnt_r) : miss_cnt_r;
    rd_cnt_nxt   = !hit ? sat_inc(rd_cnt_r)   : rd_cnt_r;
    wr_cnt_nxt   = (op_r == OP_WRITE) ? sat_inc(wr_cnt_r) : wr_cnt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_cnt_r  <= '0;
      miss_cnt_r <= '0;
      rd_cnt_r   <= '0;
      wr_cnt_r   <= '0;
    end else if (row_we) begin
      hit_cnt_r  <= hit_cnt_nxt;
      miss_cnt_r <= miss_cnt_nxt;
      rd_cnt_r   <= rd_cnt_nxt;
      wr_cnt_r   <= wr_cnt_nxt;
    end
  end

  // result register
  logic out_valid_r;
  logic out_hit_r, out_mem_read_r, out_mem_write_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (row_we) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (row_we) begin
      out_hit_r       <= hit;
      out_mem_read_r  <= !hit;
      out_mem_write_r <= (op_r == OP_WRITE);
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.hit         = out_hit_r;
  assign out_chan.mem_read    = out_mem_read_r;
  assign out_chan.mem_write   = out_mem_write_r;
  assign out_chan.hit_total   = hit_cnt_r;
  assign out_chan.miss_total  = miss_cnt_r;
  assign out_chan.read_total  = rd_cnt_r;
  assign out_chan.write_total = wr_cnt_r;

  // checks
  a_acc_to_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_LOOK))
    else $error("accepted beat did not enter compare cycle");

  a_rose_after_look: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_LOOK))
    else $error("result appeared without a compare cycle");

  a_hit_xor_read: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_hit_r != out_mem_read_r))
    else $error("hit and memory read both set or both clear");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |-> (cnt_new <= CNT_FW'(MAX_WAYS)))
    else $error("fill count beyond way count");

  a_miss_tracks_read: assert property (@(posedge clk) disable iff (!rst_n)
    row_we |=> ((miss_cnt_r == $past(miss_cnt_r)) == (rd_cnt_r == $past(rd_cnt_r)))
        || (miss_cnt_r == CNT_MAX) || (rd_cnt_r == CNT_MAX))
    else $error("miss and read counters moved apart");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the set-associative cache tag store. It runs
// directed access beats, then random phases under several register settings,
// and checks every result beat against an in-bench model of the tag store.
// ----------------------------------------------------------------------------
import sacts_pkg::*;

localparam int N_SETS      = 256;
localparam int N_WAYS      = 8;
localparam int ADDR_W      = 48;
localparam int STORE_DEPTH = N_SETS * N_WAYS;
localparam int SET_LOG_CAP = $clog2(N_SETS);
localparam int WAY_LOG_CAP = $clog2(N_WAYS);

typedef struct packed {
  logic             hit;
  logic             mem_read;
  logic             mem_write;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] read_total;
  logic [CNT_W-1:0] write_total;
} access_result_t;

class tag_store_scoreboard;
  logic                    policy;
  logic [SETS_LOG2_W-1:0]  sets_log2;
  logic [WAYS_LOG2_W-1:0]  ways_log2;
  logic [BLOCK_LOG2_W-1:0] block_log2;

  logic [ADDR_W-1:0] tag_mem   [STORE_DEPTH];
  bit                valid_mem [STORE_DEPTH];
  logic [CNT_W-1:0]  hit_cnt, miss_cnt, read_cnt, write_cnt;

  access_result_t lookup_results[$];
  int errors, checked, evictions;

  function new();
    policy     = POL_LRU;
    sets_log2  = SETS_LOG2_W'(8);
    ways_log2  = '0;
    block_log2 = BLOCK_LOG2_W'(6);
    foreach (valid_mem[i]) valid_mem[i] = 1'b0;
    hit_cnt   = '0;
    miss_cnt  = '0;
    read_cnt  = '0;
    write_cnt = '0;
    errors    = 0;
    checked   = 0;
    evictions = 0;
  endfunction

  function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_POLICY:     policy     = data[0];
      CFG_SETS_LOG2:  sets_log2  = data[SETS_LOG2_W-1:0];
      CFG_WAYS_LOG2:  ways_log2  = data[WAYS_LOG2_W-1:0];
      CFG_BLOCK_LOG2: block_log2 = data[BLOCK_LOG2_W-1:0];
      default: ;
    endcase
  endfunction

  function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] c);
    return (c == CNT_MAX) ? c : c + 1'b1;
  endfunction

  // look the access up, update the set order and push the result it yields
  function void note_access(logic op, logic [ADDR_W-1:0] addr);
    int unsigned    s_eff, w_eff, ways, base, used, pos;
    logic [ADDR_W-1:0] set_idx, tag;
    logic           hit;
    access_result_t r;
    s_eff   = (sets_log2 > SET_LOG_CAP) ? SET_LOG_CAP : sets_log2;
    w_eff   = (ways_log2 > WAY_LOG_CAP) ? WAY_LOG_CAP : ways_log2;
    ways    = 1 << w_eff;
    set_idx = (addr >> block_log2) & ((48'd1 << s_eff) - 48'd1);
    tag     = addr >> (block_log2 + s_eff);
    base    = int'(set_idx) * N_WAYS;
    hit     = 1'b0;
    pos     = 0;
    used    = 0;
    // oldest first; stop at the first empty way
    while (used < ways && valid_mem[base + used]) begin
      if (!hit && tag_mem[base + used] == tag) begin
        hit = 1'b1;
        pos = used;
      end
      used++;
    end
    if (hit) begin
      if (policy == POL_LRU) begin
        for (int unsigned j = pos; j + 1 < used; j++)
          tag_mem[base + j] = tag_mem[base + j + 1];
        tag_mem[base + used - 1] = tag;
      end
    end else if (used < ways) begin
      tag_mem[base + used]   = tag;
      valid_mem[base + used] = 1'b1;
    end else begin
      for (int unsigned j = 0; j + 1 < ways; j++)
        tag_mem[base + j] = tag_mem[base + j + 1];
      tag_mem[base + ways - 1] = tag;
      evictions++;
    end
    if (hit) begin
      hit_cnt = bump(hit_cnt);
    end else begin
      miss_cnt = bump(miss_cnt);
      read_cnt = bump(read_cnt);
    end
    if (op == OP_WRITE) write_cnt = bump(write_cnt);
    r.hit         = hit;
    r.mem_read    = !hit;
    r.mem_write   = (op == OP_WRITE);
    r.hit_total   = hit_cnt;
    r.miss_total  = miss_cnt;
    r.read_total  = read_cnt;
    r.write_total = write_cnt;
    lookup_results.push_back(r);
  endfunction

  function void same_field(string name, logic [CNT_W-1:0] want, logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h actual %0h", name, want, got);
      errors++;
    end
  endfunction

  function void check_result(access_result_t got);
    access_result_t want;
    if (lookup_results.size() == 0) begin
      $error("result beat with no access outstanding");
      errors++;
      return;
    end
    want = lookup_results.pop_front();
    checked++;
    same_field("hit",         CNT_W'(want.hit),       CNT_W'(got.hit));
    same_field("mem_read",    CNT_W'(want.mem_read),  CNT_W'(got.mem_read));
    same_field("mem_write",   CNT_W'(want.mem_write), CNT_W'(got.mem_write));
    same_field("hit_total",   want.hit_total,         got.hit_total);
    same_field("miss_total",  want.miss_total,        got.miss_total);
    same_field("read_total",  want.read_total,        got.read_total);
    same_field("write_total", want.write_total,       got.write_total);
  endfunction
endclass

module tb_top;

  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 141;   // plus 25 directed, ~1150 in all
  localparam int N_RANDOM        = N_PHASES * ITEMS_PER_PHASE;
  localparam int DRAIN_LIMIT     = 5000;
  localparam int N_RECENT        = 16;

  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sacts_in_if #(.ADDR_W(ADDR_W)) in_ch ();
  sacts_out_if                   out_ch ();

  tag_store_scoreboard sb = new();

  // idle rates in percent, set per stretch of the run
  int tx_idle_pct;
  int rx_idle_pct;
  // long receiver stall, requested by the stimulus, counted by the receiver
  int hold_ask;
  int settings;
  int accepted;

  // addresses used lately, so random traffic comes back to live blocks
  logic [ADDR_W-1:0] recent [N_RECENT];

  set_assoc_cache_tag_store #(
    .MAX_SETS    (N_SETS),
    .MAX_WAYS    (N_WAYS),
    .ADDRESS_BITS(ADDR_W)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_ch),
    .out_chan (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Monitors. All sample right at the rising edge, before any nonblocking
  // update of that edge lands, so they see what the block saw.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_we) sb.write_reg(cfg_index, cfg_wdata);
  end

  // access beat taken: predict its result now, in order of acceptance
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) begin
      sb.note_access(in_ch.op, in_ch.address);
      accepted++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.hit, out_ch.mem_read, out_ch.mem_write,
                        out_ch.hit_total, out_ch.miss_total,
                        out_ch.read_total, out_ch.write_total});
  end

  // --------------------------------------------------------------------------
  // Receiver: random ready at the current idle rate; a hold request drops
  // ready for that many cycles so the block backs up and stalls its input.
  // --------------------------------------------------------------------------
  initial begin : receiver
    int hold_left;
    hold_left    = 0;
    hold_ask     = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_ask > 0) begin
        hold_left = hold_ask - 1;
        hold_ask  = 0;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. valid is only dropped for a gap and raised again at a later
  // edge, never both in one time step. The gap before each offer is drawn at
  // the current idle rate; once raised, valid holds until the beat is taken.
  // Returns right after the accepting edge with valid still high.
  // --------------------------------------------------------------------------
  task automatic send_access(input logic op, input logic [ADDR_W-1:0] addr);
    int gap;
    gap = 0;
    while ($urandom_range(99) < tx_idle_pct) gap++;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.op      <= op;
    in_ch.address <= addr;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result beat has come back
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.lookup_results.size() != 0) @(posedge clk);
  endtask

  // registers only change with the block idle; all four are written each time,
  // policy with random upper bits that the register drops
  task automatic configure(input logic pol, input logic [CFG_DATA_W-1:0] sets,
                           input logic [CFG_DATA_W-1:0] ways, input logic [CFG_DATA_W-1:0] blk);
    wait_for_results();
    repeat (4) @(posedge clk);  // quiet time before the register writes
    cfg_we    <= 1'b1;
    cfg_index <= CFG_POLICY;
    cfg_wdata <= {(CFG_DATA_W-1)'($urandom), pol};
    @(posedge clk);
    cfg_index <= CFG_SETS_LOG2;
    cfg_wdata <= sets;
    @(posedge clk);
    cfg_index <= CFG_WAYS_LOG2;
    cfg_wdata <= ways;
    @(posedge clk);
    cfg_index <= CFG_BLOCK_LOG2;
    cfg_wdata <= blk;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    settings++;
  endtask

  // Random address shaped to the live geometry: some fully random, some
  // reusing a recent block, the rest built from a few tags over a few sets so
  // that sets fill, hit and evict.
  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       s_eff, sh, r;
    logic [ADDR_W-1:0] a, blk_mask, set_mask, tag_part;
    s_eff    = (sb.sets_log2 > SET_LOG_CAP) ? SET_LOG_CAP : sb.sets_log2;
    sh       = sb.block_log2;
    blk_mask = (48'd1 << sh) - 48'd1;
    set_mask = (48'd1 << s_eff) - 48'd1;
    r        = $urandom_range(99);
    if (r < 15) begin
      a = {16'($urandom), 32'($urandom)};
    end else if (r < 55) begin
      a = recent[$urandom_range(N_RECENT - 1)];
      a = (a & ~blk_mask) | ({16'($urandom), 32'($urandom)} & blk_mask);
    end else begin
      tag_part = ($urandom_range(9) == 0) ? {16'($urandom), 32'($urandom)}
                                          : 48'($urandom_range(11));
      a = (tag_part << (sh + s_eff))
        | ((48'($urandom_range(3)) & set_mask) << sh)
        | ({16'($urandom), 32'($urandom)} & blk_mask);
    end
    recent[$urandom_range(N_RECENT - 1)] = a;
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int n;
    in_ch.valid   = 1'b0;
    in_ch.op      = OP_READ;
    in_ch.address = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_POLICY;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    tx_idle_pct   = 21;
    rx_idle_pct   = 48;
    settings      = 0;
    accepted      = 0;
    foreach (recent[i]) recent[i] = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset geometry: LRU, 256 sets, direct mapped, 64-byte blocks.
    send_access(OP_READ,  48'h0000_0000_0000);  // cold miss
    send_access(OP_WRITE, 48'h0000_0000_0000);  // write hit
    send_access(OP_READ,  48'h0000_0000_003F);  // same block, top offset
    send_access(OP_WRITE, 48'hFFFF_FFFF_FFFF);  // all address bits high
    send_access(OP_READ,  48'h0000_0000_4000);  // same set, new tag: replaces
    send_access(OP_READ,  48'h0000_0000_0000);  // the old tag is gone

    // One set of four ways, 16-byte blocks: fill, LRU reorder, evictions.
    configure(POL_LRU, 5'd0, 5'd2, 5'd4);
    send_access(OP_READ,  48'h00);
    send_access(OP_READ,  48'h10);
    send_access(OP_READ,  48'h20);
    send_access(OP_READ,  48'h30);
    send_access(OP_READ,  48'h00);              // hit moves it newest
    send_access(OP_WRITE, 48'h40);              // evicts least recent
    send_access(OP_READ,  48'h10);
    send_access(OP_READ,  48'h00);

    // FIFO over the same, uncleared store: hits leave the order alone.
    configure(POL_FIFO, 5'd0, 5'd2, 5'd4);
    send_access(OP_READ,  48'h00);
    send_access(OP_READ,  48'h50);
    send_access(OP_READ,  48'h60);
    send_access(OP_READ,  48'h00);

    // Set count beyond the store (clamped), eight ways, 2 GiB blocks.
    configure(POL_LRU, 5'd15, 5'd3, 5'd31);
    send_access(OP_WRITE, 48'h7FFF_FFFF_FFFF);
    send_access(OP_READ,  48'h0000_8000_0000);
    send_access(OP_READ,  48'h0000_0000_0000);

    // Byte-sized blocks, 16 sets, two ways.
    configure(POL_FIFO, 5'd4, 5'd1, 5'd0);
    send_access(OP_READ,  48'h0000_0000_0001);
    send_access(OP_WRITE, 48'h0000_0000_0001);
    send_access(OP_READ,  48'h0000_0000_0011);
    send_access(OP_READ,  48'h8000_0000_0000);

    // Random phases. Idle pattern by thirds: sender light / receiver heavy,
    // then swapped, then both always ready.
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: configure(POL_LRU,  5'd8,  5'd3, 5'd6);
        1: configure(POL_FIFO, 5'd0,  5'd0, 5'd0);
        2: configure(POL_LRU,  5'd2,  5'd3, 5'd4);
        3: configure(POL_FIFO, 5'd15, 5'd3, 5'd31);
        4: configure(POL_LRU,  5'd1,  5'd2, 5'd16);
        5: configure(POL_FIFO, 5'd12, 5'd1, 5'd9);
        6: configure(POL_LRU,  5'd3,  5'd3, 5'd5);
        // raw 5-bit writes, upper bits ignored by the narrower registers
        default: configure(1'($urandom_range(1)), CFG_DATA_W'($urandom_range(31)),
                           CFG_DATA_W'($urandom_range(31)),
                           CFG_DATA_W'($urandom_range(31)));
      endcase
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        n = ph * ITEMS_PER_PHASE + k;
        if (n < N_RANDOM / 3) begin
          tx_idle_pct = 21;
          rx_idle_pct = 48;
        end else if (n < 2 * N_RANDOM / 3) begin
          tx_idle_pct = 48;
          rx_idle_pct = 21;
        end else begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
        // long receiver stall while the sender keeps offering beats
        if (ph == 2 && k == 0) hold_ask = 60;
        // sender pause until the block has fully drained
        if (ph == 5 && k == 70) wait_for_results();
        send_access(($urandom_range(1) == 1) ? OP_WRITE : OP_READ, pick_address());
      end
    end

    // Drain, bounded, then wait on for any stray beat to show up.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    for (int c = 0; c < DRAIN_LIMIT && sb.lookup_results.size() != 0; c++)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.lookup_results.size() != 0) begin
      $error("%0d result beats never arrived", sb.lookup_results.size());
      sb.errors++;
    end

    $display("tb_top: %0d accesses in, %0d results checked, %0d register settings",
             accepted, sb.checked, settings);
    $display("tb_top: %0d hits, %0d misses, %0d evictions, %0d memory writes",
             sb.hit_cnt, sb.miss_cnt, sb.evictions, sb.write_cnt);
    if (sb.errors == 0)
      $display("tb_top: PASS");
    else
      $display("tb_top: FAIL");
    $finish;
  end

  // watchdog: far beyond the slowest correct run
  initial begin : watchdog
    #2000000;
    $display("tb_top: FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
sv/sacts_pkg.sv
sv/sacts_if.sv
sv/sacts_ram.sv
sv/set_assoc_cache_tag_store.sv
bench/tb_top.sv
